// File: src/cclm_pkg.sv
// ----------------------------------------------------------------------------
// CAN channel load monitor package
// Shared field widths and operation codes.
// ----------------------------------------------------------------------------
package cclm_pkg;

    localparam logic [1:0] FUNC_FRAME = 2'd0;
    localparam logic [1:0] FUNC_EVAL  = 2'd1;
    localparam logic [1:0] FUNC_SETUP = 2'd2;
    localparam logic [1:0] FUNC_RSVD  = 2'd3;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_DOS    = 2'd1;
    localparam logic [1:0] CFG_SCALE  = 2'd2;
    localparam logic [1:0] CFG_INUSE  = 2'd3;

    localparam logic [1:0] DOS_NONE   = 2'd0;
    localparam logic [1:0] DOS_START  = 2'd1;
    localparam logic [1:0] DOS_STOP   = 2'd2;

    localparam logic [1:0] FLOW_PASS  = 2'd0;
    localparam logic [1:0] FLOW_HIGH  = 2'd1;
    localparam logic [1:0] FLOW_LOW   = 2'd2;
    localparam logic [1:0] FLOW_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  net_id;
        logic [31:0] timestamp_us;
        logic [2:0]  slot;
        logic [15:0] period_ms;
        logic [31:0] flow_max;
        logic [31:0] flow_min;
    } in_item_t;

    typedef struct packed {
        logic        matched;
        logic [2:0]  slot_index;
        logic [7:0]  channel;
        logic        due;
        logic [15:0] load_rate;
        logic [31:0] frame_count;
        logic [1:0]  dos_event;
        logic [1:0]  flow_verdict;
        logic        report;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [23:0] data;
    } cfg_item_t;

endpackage

// File: src/cclm_if.sv
// ----------------------------------------------------------------------------
// CAN channel load monitor channels
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface cclm_in_if;
    import cclm_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cclm_out_if;
    import cclm_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cclm_cfg_if;
    import cclm_pkg::*;
    logic      valid;
    logic      ready;
    cfg_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/can_channel_load_monitor.sv
// ----------------------------------------------------------------------------
// CAN channel load monitor
// Per-channel frame counting, bus load, DoS and flow range checks.
// ----------------------------------------------------------------------------
//  channel   dir   payload
//  in_ch     in    func, net_id, timestamp_us, slot, period_ms, flow_max/min
//  out_ch    out   matched ... last, one beat per result
//  cfg_ch    in    register index and write data
//
// One item at a time. A frame beat walks the slots one per cycle until a
// hit or the last slot in use. Evaluate visits each slot in use; a due
// slot runs a bit-serial multiply (count times scale, one scale bit per
// cycle) and then a restoring divide by the elapsed time. A stalled result
// holds the sequencer. Reset clears control and registers; the slot table
// is not reset.
// ----------------------------------------------------------------------------
module can_channel_load_monitor
    import cclm_pkg::*;
#(
    parameter int NUM_SLOTS = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    cclm_in_if.sink    in_ch,
    cclm_out_if.source out_ch,
    cclm_cfg_if.sink   cfg_ch
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    // Slot table, written by setup and by frame/evaluate updates.
    logic [7:0]  chan_mem  [NUM_SLOTS];
    logic [15:0] per_mem   [NUM_SLOTS];
    logic [31:0] max_mem   [NUM_SLOTS];
    logic [31:0] min_mem   [NUM_SLOTS];
    logic [31:0] cnt_mem   [NUM_SLOTS];
    logic [31:0] first_mem [NUM_SLOTS];
    logic [31:0] lastt_mem [NUM_SLOTS];
    logic        dos_mem   [NUM_SLOTS];

    logic [2:0]  mode_reg;
    logic [15:0] thr_reg;
    logic [23:0] scale_reg;
    logic [3:0]  inuse_reg;

    logic [2:0]    state_reg;
    in_item_t      item_reg;
    logic [SW-1:0] idx_reg;
    logic [63:0]   prod_reg;   // product, then dividend as quotient bits shift in
    logic [31:0]   mcand_reg;
    logic [23:0]   mplier_reg;
    logic [32:0]   rem_reg;
    logic [5:0]    step_reg;
    logic [31:0]   elap_reg;
    logic          quot_hi_reg;
    logic          outv_reg;
    out_item_t     out_reg;

    logic [CW-1:0] nact;
    logic [SW-1:0] cur;
    logic          last_slot;
    logic          hit;
    logic [31:0]   elapsed;
    logic [47:0]   per_us;
    logic [32:0]   rem_try;
    logic          ctl_free;

    // Load from the final divide step, computed with the last quotient bit.
    logic [15:0] eval_load;
    logic        q_hi_final;
    logic [31:0] q_lo_final;
    logic [1:0]  eval_dos;

    assign nact = (32'(inuse_reg) > NUM_SLOTS) ? CW'(NUM_SLOTS) : CW'(inuse_reg);
    assign cur = idx_reg;
    assign last_slot = ({1'b0, CW'(cur)} + 1'b1) >= {1'b0, nact};
    assign hit = (chan_mem[cur] == item_reg.net_id);
    assign elapsed = lastt_mem[cur] - first_mem[cur];
    assign per_us = 48'(per_mem[cur]) * 48'd1000;
    assign rem_try = {rem_reg[31:0], prod_reg[63]} - {1'b0, elap_reg};
    assign ctl_free = (state_reg == ST_IDLE);

    // A quotient wider than 16 bits saturates.
    assign q_hi_final = quot_hi_reg;
    assign q_lo_final = {prod_reg[30:0], ~rem_try[32]};
    assign eval_load = (elap_reg == 32'd0) ? 16'hFFFF :
                       (q_hi_final || q_lo_final[31:16] != 16'd0) ? 16'hFFFF
                       : q_lo_final[15:0];

    // DoS edge for the slot being finished, with mode bit 1 set: a start when the
    // load first goes above the threshold, a stop when it first falls back.
    always_comb
    begin
        eval_dos = DOS_NONE;
        if (mode_reg[1])
        begin
            if (eval_load > thr_reg)
            begin
                if (!dos_mem[cur])
                    eval_dos = DOS_START;
            end
            else if (dos_mem[cur])
                eval_dos = DOS_STOP;
        end
    end

    assign in_ch.ready  = ctl_free;
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = outv_reg;
    assign out_ch.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 3'd7;
            thr_reg   <= 16'd5120;
            scale_reg <= 24'd21600;
            inuse_reg <= 4'd0;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.data.index)
                CFG_MODE:  mode_reg  <= cfg_ch.data.data[2:0];
                CFG_DOS:   thr_reg   <= cfg_ch.data.data[15:0];
                CFG_SCALE: scale_reg <= cfg_ch.data.data;
                CFG_INUSE: inuse_reg <= cfg_ch.data.data[3:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            outv_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        item_reg <= in_ch.data;
                        idx_reg  <= '0;
                        if (in_ch.data.func == FUNC_SETUP)
                        begin
                            out_reg <= '{matched: (32'(in_ch.data.slot) < NUM_SLOTS),
                                         slot_index: in_ch.data.slot,
                                         channel: in_ch.data.net_id,
                                         flow_verdict: FLOW_NONE, last: 1'b1,
                                         default: '0};
                            if (32'(in_ch.data.slot) < NUM_SLOTS)
                            begin
                                chan_mem[SW'(in_ch.data.slot)]  <= in_ch.data.net_id;
                                per_mem[SW'(in_ch.data.slot)]   <= in_ch.data.period_ms;
                                max_mem[SW'(in_ch.data.slot)]   <= in_ch.data.flow_max;
                                min_mem[SW'(in_ch.data.slot)]   <= in_ch.data.flow_min;
                                cnt_mem[SW'(in_ch.data.slot)]   <= '0;
                                first_mem[SW'(in_ch.data.slot)] <= '0;
                                lastt_mem[SW'(in_ch.data.slot)] <= '0;
                                dos_mem[SW'(in_ch.data.slot)]   <= 1'b0;
                            end
                            outv_reg  <= 1'b1;
                            state_reg <= ST_OUT;
                        end
                        else if (in_ch.data.func == FUNC_FRAME)
                        begin
                            if (nact == '0)
                            begin
                                out_reg   <= '{last: 1'b1, default: '0};
                                outv_reg  <= 1'b1;
                                state_reg <= ST_OUT;
                            end
                            else
                                state_reg <= ST_SCAN;
                        end
                        else if (in_ch.data.func == FUNC_EVAL && nact != '0)
                            state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (item_reg.func == FUNC_FRAME)
                    begin
                        if (hit)
                        begin
                            if (cnt_mem[cur] == '0)
                                first_mem[cur] <= item_reg.timestamp_us;
                            lastt_mem[cur] <= item_reg.timestamp_us;
                            if (cnt_mem[cur] != '1)
                                cnt_mem[cur] <= cnt_mem[cur] + 32'd1;
                            out_reg <= '{matched: 1'b1, slot_index: 3'(cur),
                                         channel: chan_mem[cur],
                                         flow_verdict: FLOW_NONE, last: 1'b1,
                                         default: '0};
                            outv_reg  <= 1'b1;
                            state_reg <= ST_OUT;
                        end
                        else if (last_slot)
                        begin
                            out_reg   <= '{last: 1'b1, default: '0};
                            outv_reg  <= 1'b1;
                            state_reg <= ST_OUT;
                        end
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end
                    else if (48'(elapsed) < per_us)
                    begin
                        out_reg <= '{slot_index: 3'(cur), channel: chan_mem[cur],
                                     flow_verdict: FLOW_NONE, last: last_slot,
                                     default: '0};
                        outv_reg  <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        elap_reg   <= elapsed;
                        mcand_reg  <= cnt_mem[cur];
                        mplier_reg <= scale_reg;
                        prod_reg   <= '0;
                        step_reg   <= 6'd0;
                        state_reg  <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    // Shift-add, scale bit msb first.
                    prod_reg   <= (prod_reg << 1)
                                  + (mplier_reg[23] ? 64'(mcand_reg) : 64'd0);
                    mplier_reg <= mplier_reg << 1;
                    step_reg   <= step_reg + 6'd1;
                    if (step_reg == 6'd23)
                        state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    // Numerator is product times 256; start the divide.
                    prod_reg    <= prod_reg << 8;
                    rem_reg     <= '0;
                    quot_hi_reg <= 1'b0;
                    step_reg    <= 6'd0;
                    state_reg   <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (!rem_try[32])
                    begin
                        rem_reg  <= rem_try;
                        prod_reg <= {prod_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= {rem_reg[31:0], prod_reg[63]};
                        prod_reg <= {prod_reg[62:0], 1'b0};
                    end
                    // Quotient bits above bit 31 only feed saturation.
                    if (step_reg <= 6'd31 && !rem_try[32])
                        quot_hi_reg <= 1'b1;
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd63)
                    begin
                        state_reg <= ST_OUT;
                        outv_reg  <= 1'b1;
                    end
                end
                ST_OUT:
                begin
                    if (item_reg.func == FUNC_EVAL && !outv_reg)
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_SCAN;
                    end
                    else if (outv_reg && out_ch.ready)
                    begin
                        outv_reg <= 1'b0;
                        if (item_reg.func != FUNC_EVAL || out_reg.last)
                            state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            // A finished division turns into a due-slot result.
            if (state_reg == ST_DIV && step_reg == 6'd63)
            begin
                out_reg.matched      <= 1'b0;
                out_reg.slot_index   <= 3'(cur);
                out_reg.channel      <= chan_mem[cur];
                out_reg.due          <= 1'b1;
                out_reg.frame_count  <= mcand_reg;
                out_reg.report       <= mode_reg[0];
                out_reg.last         <= last_slot;
                out_reg.load_rate    <= eval_load;
                out_reg.dos_event    <= eval_dos;
                if (eval_dos == DOS_START)
                    dos_mem[cur] <= 1'b1;
                else if (eval_dos == DOS_STOP)
                    dos_mem[cur] <= 1'b0;
                if (!mode_reg[2])
                    out_reg.flow_verdict <= FLOW_NONE;
                else if (mcand_reg > max_mem[cur])
                    out_reg.flow_verdict <= FLOW_HIGH;
                else if (mcand_reg < min_mem[cur])
                    out_reg.flow_verdict <= FLOW_LOW;
                else
                    out_reg.flow_verdict <= FLOW_PASS;
                cnt_mem[cur]   <= '0;
                first_mem[cur] <= '0;
                lastt_mem[cur] <= '0;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result changed while stalled");
    a_busy_no_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready)
        else $error("input taken while result pending");
    a_mul_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |-> step_reg <= 6'd23)
        else $error("multiply overran");

endmodule

// File: dv/tb_can_channel_load_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN channel load monitor testbench
// Programs the slot table, then drives frame, evaluate and setup beats with
// random gaps on both channels. A mirror of the slot table and registers
// predicts every result beat. A checker compares each output beat, field by
// field, against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb_can_channel_load_monitor;
    import cclm_pkg::*;

    localparam int SLOTS = 8;
    localparam int IN_W = $bits(in_item_t);

    logic clk;
    logic rst_n;

    cclm_in_if  in_ch();
    cclm_out_if out_ch();
    cclm_cfg_if cfg_ch();

    can_channel_load_monitor #(.NUM_SLOTS(SLOTS)) DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // Clock: 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Mirror of the register file.
    logic [2:0]  mir_mode;
    logic [15:0] mir_dos_thr;
    logic [23:0] mir_scale;
    logic [3:0]  mir_in_use;

    // Mirror of the slot table.
    logic [7:0]  tbl_chan   [SLOTS];
    logic [15:0] tbl_period [SLOTS];
    logic [31:0] tbl_max    [SLOTS];
    logic [31:0] tbl_min    [SLOTS];
    logic [31:0] tbl_count  [SLOTS];
    logic [31:0] tbl_first  [SLOTS];
    logic [31:0] tbl_last   [SLOTS];
    logic        tbl_dos    [SLOTS];

    // Results predicted but not yet seen on the output channel.
    out_item_t awaited_results[$];

    int mismatches;
    int send_idle_pct;
    int stall_pct;

    // Running bus time in microseconds; wraps naturally at 32 bits.
    logic [31:0] bus_now_us;

    // Bus load in 1/256 percent, saturated; zero elapsed time saturates too.
    function automatic logic [15:0] bus_load(logic [31:0] cnt, logic [31:0] elapsed);
        logic [63:0] num;
        logic [63:0] q;
        if (elapsed == 32'd0)
            return 16'hFFFF;
        num = ({32'd0, cnt} * {40'd0, mir_scale}) << 8;
        q = num / {32'd0, elapsed};
        return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
    endfunction

    function automatic out_item_t blank_result(logic [2:0] idx, logic [7:0] chan);
        out_item_t r;
        r = '0;
        r.slot_index = idx;
        r.channel = chan;
        r.flow_verdict = FLOW_NONE;
        r.last = 1'b1;
        return r;
    endfunction

    // Updates the mirror for one accepted input beat and queues its results.
    task automatic predict_monitor(in_item_t it);
        int n;
        out_item_t r;
        logic [31:0] elapsed;
        logic found;
        n = (mir_in_use > SLOTS) ? SLOTS : int'(mir_in_use);
        found = 1'b0;
        case (it.func)
            FUNC_FRAME:
            begin
                for (int i = 0; i < n && !found; i++)
                begin
                    if (tbl_chan[i] == it.net_id)
                    begin
                        found = 1'b1;
                        if (tbl_count[i] == 32'd0)
                            tbl_first[i] = it.timestamp_us;
                        tbl_last[i] = it.timestamp_us;
                        if (tbl_count[i] != 32'hFFFF_FFFF)
                            tbl_count[i] = tbl_count[i] + 1;
                        r = blank_result(3'(i), tbl_chan[i]);
                        r.matched = 1'b1;
                        awaited_results.push_back(r);
                    end
                end
                if (!found)
                begin
                    // A miss reports nothing but the final flag.
                    r = '0;
                    r.last = 1'b1;
                    awaited_results.push_back(r);
                end
            end
            FUNC_EVAL:
            begin
                for (int i = 0; i < n; i++)
                begin
                    r = blank_result(3'(i), tbl_chan[i]);
                    r.last = (i + 1 == n);
                    elapsed = tbl_last[i] - tbl_first[i];
                    if ({32'd0, elapsed} >= {48'd0, tbl_period[i]} * 64'd1000)
                    begin
                        r.due = 1'b1;
                        r.frame_count = tbl_count[i];
                        r.load_rate = bus_load(tbl_count[i], elapsed);
                        r.dos_event = DOS_NONE;
                        if (mir_mode[1])
                        begin
                            if (r.load_rate > mir_dos_thr)
                            begin
                                if (!tbl_dos[i])
                                begin
                                    tbl_dos[i] = 1'b1;
                                    r.dos_event = DOS_START;
                                end
                            end
                            else if (tbl_dos[i])
                            begin
                                tbl_dos[i] = 1'b0;
                                r.dos_event = DOS_STOP;
                            end
                        end
                        if (mir_mode[2])
                        begin
                            if (tbl_count[i] > tbl_max[i])
                                r.flow_verdict = FLOW_HIGH;
                            else if (tbl_count[i] < tbl_min[i])
                                r.flow_verdict = FLOW_LOW;
                            else
                                r.flow_verdict = FLOW_PASS;
                        end
                        r.report = mir_mode[0];
                        // The slot starts a fresh measuring period.
                        tbl_count[i] = 32'd0;
                        tbl_first[i] = 32'd0;
                        tbl_last[i] = 32'd0;
                    end
                    awaited_results.push_back(r);
                end
            end
            FUNC_SETUP:
            begin
                tbl_chan[it.slot] = it.net_id;
                tbl_period[it.slot] = it.period_ms;
                tbl_max[it.slot] = it.flow_max;
                tbl_min[it.slot] = it.flow_min;
                tbl_count[it.slot] = 32'd0;
                tbl_first[it.slot] = 32'd0;
                tbl_last[it.slot] = 32'd0;
                tbl_dos[it.slot] = 1'b0;
                r = blank_result(it.slot, it.net_id);
                r.matched = 1'b1;
                awaited_results.push_back(r);
            end
            default:
            begin
                // Unknown function codes are dropped without a result.
            end
        endcase
    endtask

    // Sends one input beat. Valid stays high when the next beat follows at
    // once, so it is only ever given one value per clock edge.
    task automatic send_item(in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_monitor(it);
    endtask

    // Waits until every predicted result has come out, then lets the block
    // finish any beat that produces nothing (empty evaluate, unknown code).
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data.index <= idx;
        cfg_ch.data.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            CFG_MODE:  mir_mode = value[2:0];
            CFG_DOS:   mir_dos_thr = value[15:0];
            CFG_SCALE: mir_scale = value;
            default:   mir_in_use = value[3:0];
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(logic [2:0] mode, logic [15:0] thr, logic [23:0] scale,
                            logic [3:0] in_use);
        wait_idle();
        write_reg(CFG_MODE, {21'd0, mode});
        write_reg(CFG_DOS, {8'd0, thr});
        write_reg(CFG_SCALE, scale);
        write_reg(CFG_INUSE, {20'd0, in_use});
    endtask

    // Unused fields of a beat carry random bits so that every input bit moves.
    function automatic in_item_t frame_beat(logic [7:0] id, logic [31:0] ts);
        in_item_t it;
        it = IN_W'({$urandom, $urandom, $urandom, $urandom});
        it.func = FUNC_FRAME;
        it.net_id = id;
        it.timestamp_us = ts;
        return it;
    endfunction

    function automatic in_item_t eval_beat();
        in_item_t it;
        it = IN_W'({$urandom, $urandom, $urandom, $urandom});
        it.func = FUNC_EVAL;
        return it;
    endfunction

    function automatic in_item_t setup_beat(logic [2:0] s, logic [7:0] id,
                                            logic [15:0] per, logic [31:0] fmax,
                                            logic [31:0] fmin);
        in_item_t it;
        it = IN_W'({$urandom, $urandom, $urandom, $urandom});
        it.func = FUNC_SETUP;
        it.slot = s;
        it.net_id = id;
        it.period_ms = per;
        it.flow_max = fmax;
        it.flow_min = fmin;
        return it;
    endfunction

    // Frame on a channel that sits in the table, advancing bus time.
    task automatic send_known_frame(int step_max);
        bus_now_us = bus_now_us + 32'($urandom_range(step_max));
        send_item(frame_beat(tbl_chan[$urandom_range(SLOTS - 1)], bus_now_us));
    endtask

    // Every slot is programmed before any slot count is raised above zero,
    // so no lookup or evaluation ever touches an unwritten slot.
    task automatic test_table_setup();
        send_item(setup_beat(3'd0, 8'h00, 16'd1,     32'd5,          32'd1));
        send_item(setup_beat(3'd1, 8'hFF, 16'd0,     32'd0,          32'd0));
        send_item(setup_beat(3'd2, 8'h21, 16'd2,     32'hFFFF_FFFF,  32'd0));
        send_item(setup_beat(3'd3, 8'h21, 16'hFFFF,  32'd3,          32'd2));
        send_item(setup_beat(3'd4, 8'h42, 16'd0,     32'd2,          32'hFFFF_FFFF));
        send_item(setup_beat(3'd5, 8'h55, 16'd3,     32'd10,         32'd4));
        send_item(setup_beat(3'd6, 8'h66, 16'd1,     32'd1,          32'd1));
        send_item(setup_beat(3'd7, 8'h77, 16'd0,     32'd0,          32'd0));
    endtask

    task automatic test_directed();
        set_regs(3'd7, 16'd5120, 24'd21600, 4'd8);
        // Channel missing from the table.
        send_item(frame_beat(8'hEE, bus_now_us));
        // Duplicate channel id: only the first slot may count it.
        send_item(frame_beat(8'h21, 32'hFFFF_FF00));
        // Time wraps between first and last stamp of slot 0.
        send_item(frame_beat(8'h00, 32'hFFFF_FF00));
        send_item(frame_beat(8'h00, 32'h0000_0400));
        send_item(frame_beat(8'h00, 32'h0000_0500));
        // One frame only: zero elapsed time on a zero period saturates.
        send_item(frame_beat(8'h42, 32'h1234_5678));
        send_item(frame_beat(8'h55, 32'd1000));
        send_item(frame_beat(8'h55, 32'd4000));
        send_item(frame_beat(8'h21, 32'h0000_0700));
        // Unknown function code.
        send_item('{func: FUNC_RSVD, net_id: 8'hA5, timestamp_us: 32'hA5A5_A5A5,
                    slot: 3'd5, period_ms: 16'h5A5A, flow_max: 32'h5A5A_5A5A,
                    flow_min: 32'hA5A5_A5A5});
        send_item(eval_beat());
        // A second pass sends light traffic on channels 0x55 and 0x66.
        bus_now_us = 32'd100_000;
        send_item(frame_beat(8'h55, bus_now_us));
        send_item(frame_beat(8'h55, bus_now_us + 32'd50_000));
        send_item(frame_beat(8'h66, bus_now_us + 32'd20_000));
        send_item(eval_beat());
        bus_now_us = bus_now_us + 32'd60_000;
    endtask

    // Register extremes, each followed by a short burst and an evaluation.
    task automatic test_register_extremes();
        set_regs(3'd0, 16'd0, 24'd1, 4'd0);
        repeat (3) send_known_frame(500);
        send_item(eval_beat());
        set_regs(3'd7, 16'hFFFF, 24'hFF_FFFF, 4'd15);
        repeat (6) send_known_frame(800);
        send_item(eval_beat());
        set_regs(3'd2, 16'd0, 24'd1, 4'd1);
        repeat (3) send_known_frame(1500);
        send_item(eval_beat());
        set_regs(3'd5, 16'd300, 24'd21600, 4'd9);
        repeat (6) send_known_frame(1500);
        send_item(eval_beat());
    endtask

    // Mostly well-formed traffic on known channels with regular evaluations;
    // the rest is unknown ids, random stamps, reprogramming and junk codes.
    task automatic run_traffic(int items);
        int pick;
        in_item_t junk;
        for (int k = 0; k < items; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 62)
            begin
                if ($urandom_range(19) == 0)
                    bus_now_us = $urandom;
                send_known_frame(2500);
            end
            else if (pick < 70)
                send_item(frame_beat(8'($urandom), $urandom));
            else if (pick < 86)
                send_item(eval_beat());
            else if (pick < 96)
            begin
                if ($urandom_range(9) == 0)
                    send_item(setup_beat(3'($urandom), 8'($urandom), 16'($urandom),
                                         $urandom, $urandom));
                else
                    send_item(setup_beat(3'($urandom), 8'($urandom_range(8'h10, 8'h17)),
                                         16'($urandom_range(6)),
                                         $urandom_range(20), $urandom_range(8)));
            end
            else
            begin
                junk = IN_W'({$urandom, $urandom, $urandom, $urandom});
                junk.func = FUNC_RSVD;
                send_item(junk);
            end
        end
    endtask

    task automatic test_random_phase(int items);
        for (int blk = 0; blk < 3; blk++)
        begin
            set_regs(3'($urandom), 16'($urandom_range(12000)),
                     24'($urandom_range(1, 60000)),
                     ($urandom_range(4) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(8)));
            run_traffic(items / 3);
        end
    endtask

    // Output checker and receiver stalls. Both sample the values that held
    // at the clock edge, before this edge's updates land.
    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %p", got);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got.matched !== want.matched || got.slot_index !== want.slot_index ||
                    got.channel !== want.channel || got.due !== want.due ||
                    got.load_rate !== want.load_rate ||
                    got.frame_count !== want.frame_count ||
                    got.dos_event !== want.dos_event ||
                    got.flow_verdict !== want.flow_verdict ||
                    got.report !== want.report || got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p, got %p", want, got);
                end
            end
        end
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= '0;
        rst_n <= 1'b0;
        mismatches = 0;
        send_idle_pct = 14;
        stall_pct = 83;
        bus_now_us = 32'd0;
        mir_mode = 3'd7;
        mir_dos_thr = 16'd5120;
        mir_scale = 24'd21600;
        mir_in_use = 4'd0;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_chan[i] = '0;
            tbl_period[i] = '0;
            tbl_max[i] = '0;
            tbl_min[i] = '0;
            tbl_count[i] = '0;
            tbl_first[i] = '0;
            tbl_last[i] = '0;
            tbl_dos[i] = 1'b0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_setup();
        test_directed();
        test_register_extremes();
        test_random_phase(72);
        send_idle_pct = 83;
        stall_pct = 14;
        test_random_phase(72);
        send_idle_pct = 0;
        stall_pct = 0;
        test_random_phase(72);

        wait_idle();
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("can_channel_load_monitor test passed");
        else
            $display("can_channel_load_monitor test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("can_channel_load_monitor test failed");
        $finish;
    end

endmodule

// File: filelist.f
src/cclm_pkg.sv
src/cclm_if.sv
src/can_channel_load_monitor.sv
dv/tb_can_channel_load_monitor.sv
